>>> rtl/gcbb_pkg.sv
package gcbb_pkg;

  localparam int FRAME_MAX_WIDTH_DEF  = 256;
  localparam int FRAME_MAX_HEIGHT_DEF = 256;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_ROWS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_COLOR   = 3'd6;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  typedef struct packed {
    logic [8:0]  frame_width;
    logic [8:0]  frame_height;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_rows;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [23:0] text_color;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] address;
    pixel_t      pix;
    logic [7:0]  coverage;
    logic        hit;
    logic        done;
  } item_t;

endpackage

>>> rtl/gcbb_ram.sv
module gcbb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/gcbb_blend.sv
module gcbb_blend (
  input  logic [23:0]          text_color,
  input  logic [7:0]           coverage,
  input  gcbb_pkg::pixel_t     dst,
  output gcbb_pkg::pixel_t     mixed
);

  function automatic logic [7:0] mix(input logic [7:0] c, input logic [7:0] d,
                                     input logic [7:0] a);
    logic [15:0] p0;
    logic [15:0] p1;
    logic [16:0] sum;
    p0  = 16'(c) * 16'(a);
    p1  = 16'(d) * 16'(8'd255 - a);
    sum = 17'(p0) + 17'(p1);
    return sum[15:8];
  endfunction

  always_comb begin
    mixed.r = mix(text_color[23:16], dst.r, coverage);
    mixed.g = mix(text_color[15:8], dst.g, coverage);
    mixed.b = mix(text_color[7:0], dst.b, coverage);
    mixed.a = dst.a;
  end

endmodule

>>> rtl/gcbb_place.sv
module gcbb_place #(
  parameter int FRAME_MAX_WIDTH  = gcbb_pkg::FRAME_MAX_WIDTH_DEF,
  parameter int FRAME_MAX_HEIGHT = gcbb_pkg::FRAME_MAX_HEIGHT_DEF,
  localparam int DEPTH = FRAME_MAX_WIDTH * FRAME_MAX_HEIGHT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [1:0]          cmd,
  input  logic [15:0]         pixel_address,
  input  logic [7:0]          write_red,
  input  logic [7:0]          write_green,
  input  logic [7:0]          write_blue,
  input  logic [7:0]          write_alpha,
  input  logic [7:0]          coverage,
  input  gcbb_pkg::cfg_t      cfg,
  output logic                s2_valid,
  output gcbb_pkg::item_t     s2_item,
  output logic [AW-1:0]       s2_addr
);

  logic [7:0] col, col_next;
  logic [7:0] row, row_next;
  logic [7:0] col_inc, row_inc;
  logic       done_now;
  logic       accept;
  logic [16:0] x_sum, y_sum;

  logic            s1_valid;
  gcbb_pkg::item_t s1_item;
  logic [16:0]     s1_x, s1_y;

  logic [8:0]  fw, fh;
  logic        in_frame, in_store, s1_hit;
  logic [17:0] prod;

  gcbb_pkg::item_t s2_body;
  logic [17:0]     s2_prod;
  logic [8:0]      s2_x;
  logic [17:0]     ad;

  assign accept = in_valid && adv;

  // glyph position counters, row-major with wrap at the glyph size
  always_comb begin
    col_inc  = col + 8'd1;
    row_inc  = row + 8'd1;
    col_next = col_inc;
    row_next = row;
    done_now = 1'b0;
    if (col_inc == cfg.glyph_width) begin
      col_next = 8'd0;
      row_next = row_inc;
      if (row_inc == cfg.glyph_rows) begin
        row_next = 8'd0;
        done_now = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= 8'd0;
      row <= 8'd0;
    end else if (accept && (gcbb_pkg::cmd_t'(cmd) == gcbb_pkg::CMD_SAMPLE)) begin
      col <= col_next;
      row <= row_next;
    end
  end

  assign x_sum = {cfg.origin_x[15], cfg.origin_x} + {9'd0, col};
  assign y_sum = {cfg.origin_y[15], cfg.origin_y} + {9'd0, row};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item.cmd      <= gcbb_pkg::cmd_t'(cmd);
      s1_item.address  <= pixel_address;
      s1_item.pix      <= {write_red, write_green, write_blue, write_alpha};
      s1_item.coverage <= coverage;
      s1_item.hit      <= 1'b0;
      s1_item.done     <= done_now && (gcbb_pkg::cmd_t'(cmd) == gcbb_pkg::CMD_SAMPLE);
      s1_x             <= x_sum;
      s1_y             <= y_sum;
    end
  end

  // frame size clamp, frame bounds and store range checks, and row offset
  always_comb begin
    fw = (32'(cfg.frame_width) > 32'(FRAME_MAX_WIDTH)) ? 9'(FRAME_MAX_WIDTH)
                                                       : cfg.frame_width;
    fh = (32'(cfg.frame_height) > 32'(FRAME_MAX_HEIGHT)) ? 9'(FRAME_MAX_HEIGHT)
                                                         : cfg.frame_height;
    in_frame = !s1_x[16] && !s1_y[16] && (s1_x[15:0] < 16'(fw)) &&
               (s1_y[15:0] < 16'(fh));
    in_store = 32'(s1_item.address) < 32'(DEPTH);
    prod = 18'(s1_y[8:0]) * 18'(fw);
    case (s1_item.cmd)
      gcbb_pkg::CMD_SAMPLE: s1_hit = in_frame;
      gcbb_pkg::CMD_WRITE:  s1_hit = in_store;
      gcbb_pkg::CMD_READ:   s1_hit = in_store;
      default:              s1_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_body     <= s1_item;
      s2_body.hit <= s1_hit;
      s2_prod     <= prod;
      s2_x        <= s1_x[8:0];
    end
  end

  assign ad = s2_prod + 18'(s2_x);

  always_comb begin
    s2_item = s2_body;
    s2_addr = AW'(s2_body.address);
    if (s2_body.cmd == gcbb_pkg::CMD_SAMPLE) begin
      s2_item.address = ad[15:0];
      s2_addr         = AW'(ad);
    end
  end

endmodule

>>> rtl/glyph_coverage_blend_blit_core.sv
// glyph coverage blend blitter
// keeps an rgba frame store of FRAME_MAX_WIDTH x FRAME_MAX_HEIGHT words and
// takes one request per cycle on the in_valid / in_ready channel: a pixel
// write, a pixel read, or the next glyph coverage sample in row-major order
// each request gives exactly one result on the out_valid / out_ready channel
// samples are placed at origin plus (row, col) from internal counters; those
// inside the frame blend the text colour over the stored pixel
// a result is offered from the output register after its request passes the placement and memory stages
// throughput: one request per cycle sustained while the output does not stall; the frame store read and the
// write-back are pipelined, and a read or sample that reads the entry the previous
// request is writing takes the new word from a forwarding register
// when a result waits and out_ready is low, the output register holds and the
// whole pipeline stalls; in_ready drops in that same cycle
// reset clears the counters and all valid bits and sets the configuration registers to their defaults;
// the frame store itself is not cleared and must be written before it is read
// configuration is written through cfg_write / cfg_index / cfg_data while
// no request is in flight
module glyph_coverage_blend_blit_core #(
  parameter int FRAME_MAX_WIDTH  = gcbb_pkg::FRAME_MAX_WIDTH_DEF,
  parameter int FRAME_MAX_HEIGHT = gcbb_pkg::FRAME_MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [gcbb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gcbb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       cmd,
  input  logic [15:0]                      pixel_address,
  input  logic [7:0]                       write_red,
  input  logic [7:0]                       write_green,
  input  logic [7:0]                       write_blue,
  input  logic [7:0]                       write_alpha,
  input  logic [7:0]                       coverage,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [15:0]                      out_address,
  output logic                             written,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic [7:0]                       out_alpha,
  output logic                             glyph_done
);

  localparam int DEPTH = FRAME_MAX_WIDTH * FRAME_MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  gcbb_pkg::cfg_t cfg;

  logic adv;

  // placement stages
  logic            s2_valid;
  gcbb_pkg::item_t s2_item;
  logic [AW-1:0]   s2_addr;

  // memory stage
  logic            s3_valid;
  gcbb_pkg::item_t s3_item;
  logic [AW-1:0]   s3_addr;

  logic             ram_we;
  gcbb_pkg::pixel_t ram_wdata;
  gcbb_pkg::pixel_t ram_rdata;
  gcbb_pkg::pixel_t dst;
  gcbb_pkg::pixel_t mixed;

  logic             fwd_hit;
  gcbb_pkg::pixel_t fwd_data;

  logic [15:0]      res_address;
  logic             res_written;
  gcbb_pkg::pixel_t res_pix;
  logic             res_done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= 9'd256;
      cfg.frame_height <= 9'd256;
      cfg.glyph_width  <= 8'd1;
      cfg.glyph_rows   <= 8'd1;
      cfg.origin_x     <= 16'd0;
      cfg.origin_y     <= 16'd0;
      cfg.text_color   <= 24'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        gcbb_pkg::REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[8:0];
        gcbb_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[8:0];
        gcbb_pkg::REG_GLYPH_WIDTH:  cfg.glyph_width  <= cfg_data[7:0];
        gcbb_pkg::REG_GLYPH_ROWS:   cfg.glyph_rows   <= cfg_data[7:0];
        gcbb_pkg::REG_ORIGIN_X:     cfg.origin_x     <= cfg_data[15:0];
        gcbb_pkg::REG_ORIGIN_Y:     cfg.origin_y     <= cfg_data[15:0];
        gcbb_pkg::REG_TEXT_COLOR:   cfg.text_color   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // the whole pipeline moves whenever the output register can take a result
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // counters, frame placement and address forming
  gcbb_place #(
    .FRAME_MAX_WIDTH (FRAME_MAX_WIDTH),
    .FRAME_MAX_HEIGHT(FRAME_MAX_HEIGHT)
  ) u_place (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (in_valid),
    .cmd          (cmd),
    .pixel_address(pixel_address),
    .write_red    (write_red),
    .write_green  (write_green),
    .write_blue   (write_blue),
    .write_alpha  (write_alpha),
    .coverage     (coverage),
    .cfg          (cfg),
    .s2_valid     (s2_valid),
    .s2_item      (s2_item),
    .s2_addr      (s2_addr)
  );

  // frame store: read issued from the address stage, written back one stage on
  gcbb_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s3_addr),
    .wdata(ram_wdata),
    .re   (adv),
    .raddr(s2_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_item <= s2_item;
      s3_addr <= s2_addr;
    end
  end

  // back-to-back access to one entry: the read saw the old word, so the word
  // being written is kept aside and used instead
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (adv) begin
      fwd_hit <= ram_we && s2_valid && (s2_addr == s3_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_data <= ram_wdata;
    end
  end

  assign dst = fwd_hit ? fwd_data : ram_rdata;

  gcbb_blend u_blend (
    .text_color(cfg.text_color),
    .coverage  (s3_item.coverage),
    .dst       (dst),
    .mixed     (mixed)
  );

  // write-back: pixel writes store the request's pixel, samples the blend
  assign ram_we = adv && s3_valid && s3_item.hit &&
                  ((s3_item.cmd == gcbb_pkg::CMD_WRITE) ||
                   (s3_item.cmd == gcbb_pkg::CMD_SAMPLE));
  assign ram_wdata = (s3_item.cmd == gcbb_pkg::CMD_SAMPLE) ? mixed : s3_item.pix;

  // result forming
  always_comb begin
    res_address = 16'd0;
    res_written = 1'b0;
    res_pix     = '0;
    res_done    = 1'b0;
    case (s3_item.cmd)
      gcbb_pkg::CMD_WRITE: begin
        res_address = s3_item.address;
        res_written = s3_item.hit;
        res_pix     = s3_item.pix;
      end
      gcbb_pkg::CMD_READ: begin
        res_address = s3_item.address;
        if (s3_item.hit) begin
          res_pix = dst;
        end
      end
      gcbb_pkg::CMD_SAMPLE: begin
        res_done = s3_item.done;
        if (s3_item.hit) begin
          res_address = s3_item.address;
          res_written = 1'b1;
          res_pix     = mixed;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_address <= res_address;
      written     <= res_written;
      out_red     <= res_pix.r;
      out_green   <= res_pix.g;
      out_blue    <= res_pix.b;
      out_alpha   <= res_pix.a;
      glyph_done  <= res_done;
    end
  end

`ifndef NO_ASSERTIONS
  // forwarding only follows a write-back in the cycle before, or is held by a stall
  a_fwd_after_write: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> ($past(ram_we) || !$past(adv)))
    else $error("forwarding flag set without a preceding write");

  // write-back never leaves the frame store
  a_write_in_store: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (32'(s3_addr) < 32'(DEPTH)))
    else $error("frame store write beyond its depth");

  // a stall freezes the read word that the held request depends on
  a_stall_holds_read: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(ram_rdata) && $stable(fwd_hit))
    else $error("read data changed during a stall");

  // a finished glyph is only flagged by a sample
  a_done_from_sample: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_item.done) |-> (s3_item.cmd == gcbb_pkg::CMD_SAMPLE))
    else $error("glyph end flagged on a non-sample request");
`endif

endmodule
